>>> rtl/gta_pkg.sv
// Shared types and constants for the generation-tagged ID allocator.
// Used by every module under rtl except gta_ram; depends on nothing else.
package gta_pkg;

  localparam int SLOTS    = 1024;
  localparam int ROUNDS   = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int ROUND_W  = $clog2(ROUNDS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [ROUND_W-1:0]  round_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_LOOKUP  = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_SLOT     = 2'd1,
    ST_ZERO_HANDLE = 2'd2,
    ST_BAD_ID      = 2'd3
  } status_t;

  // One entry per cycle of the clearing pass after reset.
  typedef struct packed {
    logic  en;
    slot_t idx;
  } init_t;

  typedef struct packed {
    logic  pop;
    logic  push;
    slot_t push_slot;
  } fq_cmd_t;

  typedef struct packed {
    logic    alloc;
    logic    rel;
    slot_t   slot;
    round_t  round;
    handle_t handle;
  } st_cmd_t;

  typedef struct packed {
    logic   valid;
    round_t round;
  } tag_t;

endpackage

>>> rtl/generation_tagged_id_allocator_core.sv
// Top level of the generation-tagged ID allocator: request stage, decision logic,
// round bookkeeping and result register. Depends on gta_pkg, gta_free_q, gta_slot_tab.
//
// Usage:
//   A request (in_func, in_id_in, in_object_handle) is taken at a rising edge with
//   start high and busy low. in_func selects allocate, release, lookup or no-op.
//   Every request gives exactly one result: out_valid is high for one cycle with
//   out_status, out_id_out, out_handle_out and out_used_slots. The receiver cannot
//   stall; the result must be taken in that cycle.
//   The request is registered in the request stage and its result in the result
//   register. Throughput is one request per cycle once busy is low: the slot tables
//   and the free queue are each read once and written at most once per request,
//   with write forwarding so a request may use a slot touched by the one just
//   before it. After reset a clearing pass marks every slot invalid and loads
//   the free queue with slots 0 to 1023; busy is high during that pass.
//   cfg_we with cfg_wdata loads the current round number; write it only while no
//   request is in flight. The round number resets to 0.
module generation_tagged_id_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_id_in,
  input  logic [31:0] in_object_handle,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_id_out,
  output logic [31:0] out_handle_out,
  output logic [10:0] out_used_slots,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);

  // Clearing pass after reset.
  logic             clr_active_r;
  gta_pkg::slot_t   clr_idx_r;
  gta_pkg::init_t   init;

  // Request stage.
  logic             accept;
  logic             s1_valid_r;
  gta_pkg::func_t   s1_func_r;
  logic [gta_pkg::ID_W-1:0] s1_id_r;
  gta_pkg::handle_t s1_handle_r;

  // Allocator state.
  gta_pkg::cnt_t    use_r, use_nxt;
  gta_pkg::round_t  round_r, round_nxt;
  gta_pkg::cnt_t    used_r, used_nxt;
  gta_pkg::cnt_t    quota_r, quota_nxt;

  // Table interfaces.
  gta_pkg::fq_cmd_t fq_cmd;
  gta_pkg::st_cmd_t st_cmd;
  gta_pkg::slot_t   free_slot;
  gta_pkg::cnt_t    fill;
  gta_pkg::tag_t    tag;
  gta_pkg::handle_t hnd_rd;

  gta_pkg::slot_t   id_slot;
  gta_pkg::round_t  id_round;
  logic             hit, empty, full;

  gta_pkg::status_t status;
  logic [gta_pkg::ID_W-1:0] id_res;
  gta_pkg::handle_t hnd_res;

  // Result register.
  logic             out_valid_r;
  gta_pkg::status_t out_status_r;
  logic [gta_pkg::ID_W-1:0] out_id_r;
  gta_pkg::handle_t out_handle_r;
  gta_pkg::cnt_t    out_used_r;

  assign init.en  = clr_active_r;
  assign init.idx = clr_idx_r;
  assign busy     = clr_active_r;
  assign accept   = start & ~clr_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      clr_idx_r <= gta_pkg::slot_t'(clr_idx_r + 1'b1);
      if (clr_idx_r == gta_pkg::slot_t'(gta_pkg::SLOTS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r   <= gta_pkg::func_t'(in_func);
    s1_id_r     <= in_id_in;
    s1_handle_r <= in_object_handle;
  end

  gta_free_q u_free_q (
    .clk         (clk),
    .rst_n       (rst_n),
    .init_i      (init),
    .cmd_i       (fq_cmd),
    .free_slot_o (free_slot),
    .fill_o      (fill)
  );

  gta_slot_tab u_slot_tab (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_i    (init),
    .cmd_i     (st_cmd),
    .rd_slot_i (in_id_in[gta_pkg::SLOT_W-1:0]),
    .tag_o     (tag),
    .handle_o  (hnd_rd)
  );

  assign id_slot  = s1_id_r[gta_pkg::SLOT_W-1:0];
  assign id_round = s1_id_r[gta_pkg::ID_W-1:gta_pkg::SLOT_W];
  assign hit      = tag.valid && (tag.round == id_round);
  assign empty    = (fill == '0);
  assign full     = (fill == gta_pkg::cnt_t'(gta_pkg::SLOTS));

  always_comb begin
    status    = gta_pkg::ST_OK;
    id_res    = '0;
    hnd_res   = '0;
    use_nxt   = use_r;
    round_nxt = round_r;
    used_nxt  = used_r;
    quota_nxt = quota_r;
    fq_cmd    = '0;
    st_cmd    = '0;
    st_cmd.handle = s1_handle_r;
    if (s1_valid_r) begin
      case (s1_func_r)
        gta_pkg::FUNC_ALLOC: begin
          if (s1_handle_r == '0) begin
            status = gta_pkg::ST_ZERO_HANDLE;
          end else begin
            // A spent quota opens a new round before this allocate is counted.
            if (used_r >= quota_r) begin
              quota_nxt = gta_pkg::cnt_t'(gta_pkg::SLOTS) - use_r;
              round_nxt = (round_r == gta_pkg::round_t'(gta_pkg::ROUNDS - 1))
                          ? '0 : gta_pkg::round_t'(round_r + 1'b1);
              used_nxt  = gta_pkg::cnt_t'(1);
            end else begin
              used_nxt  = gta_pkg::cnt_t'(used_r + 1'b1);
            end
            if (empty) begin
              status = gta_pkg::ST_NO_SLOT;
            end else begin
              fq_cmd.pop   = 1'b1;
              st_cmd.alloc = 1'b1;
              st_cmd.slot  = free_slot;
              st_cmd.round = round_nxt;
              use_nxt      = gta_pkg::cnt_t'(use_r + 1'b1);
              id_res       = {round_nxt, free_slot};
            end
          end
        end
        gta_pkg::FUNC_RELEASE: begin
          if (hit && !full) begin
            fq_cmd.push      = 1'b1;
            fq_cmd.push_slot = id_slot;
            st_cmd.rel       = 1'b1;
            st_cmd.slot      = id_slot;
            if (use_r != '0) begin
              use_nxt = gta_pkg::cnt_t'(use_r - 1'b1);
            end
          end else begin
            status = gta_pkg::ST_BAD_ID;
          end
        end
        gta_pkg::FUNC_LOOKUP: begin
          if (hit) begin
            hnd_res = hnd_rd;
          end else begin
            status = gta_pkg::ST_BAD_ID;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r       <= '0;
      round_r     <= '0;
      used_r      <= '0;
      quota_r     <= gta_pkg::cnt_t'(gta_pkg::SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      use_r       <= use_nxt;
      used_r      <= used_nxt;
      quota_r     <= quota_nxt;
      out_valid_r <= s1_valid_r;
      if (cfg_we) begin
        round_r <= gta_pkg::round_t'(cfg_wdata % gta_pkg::ROUNDS);
      end else begin
        round_r <= round_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= status;
    out_id_r     <= id_res;
    out_handle_r <= hnd_res;
    out_used_r   <= use_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_id_out     = out_id_r;
  assign out_handle_out = out_handle_r;
  assign out_used_slots = out_used_r;

  // Every accepted item yields exactly one result, in the cycle after the request stage.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r == $past(accept) |-> ##1 out_valid_r == $past(s1_valid_r))
    else $error("result strobe does not follow the request stage");

  // Slots in use and slots in the free queue always account for the whole table.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, use_r} + {1'b0, fill}) == (gta_pkg::CNT_W + 1)'(gta_pkg::SLOTS))
    else $error("used count and free queue fill disagree");

  // No item is in flight while the clearing pass runs.
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r && !out_valid_r)
    else $error("item in flight during clearing pass");

endmodule

>>> rtl/gta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gta_free_q.sv
// Free-slot queue: ring buffer of slot indices with head pointer and fill count.
// Depends on gta_pkg and gta_ram.
module gta_free_q (
  input  logic             clk,
  input  logic             rst_n,
  input  gta_pkg::init_t   init_i,
  input  gta_pkg::fq_cmd_t cmd_i,
  output gta_pkg::slot_t   free_slot_o,
  output gta_pkg::cnt_t    fill_o
);

  gta_pkg::slot_t head_r, head_nxt;
  gta_pkg::cnt_t  fill_r, fill_nxt;
  gta_pkg::slot_t tail;
  gta_pkg::slot_t ram_q;

  logic           wr_en;
  gta_pkg::slot_t wr_addr, wr_data;
  logic           wr_en_r;
  gta_pkg::slot_t wr_addr_r, wr_data_r;

  assign tail = gta_pkg::slot_t'(head_r + fill_r[gta_pkg::SLOT_W-1:0]);

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd_i.pop) begin
      head_nxt = gta_pkg::slot_t'(head_r + 1'b1);
      fill_nxt = gta_pkg::cnt_t'(fill_r - 1'b1);
    end else if (cmd_i.push) begin
      fill_nxt = gta_pkg::cnt_t'(fill_r + 1'b1);
    end
  end

  // The clearing pass loads every entry with its own index.
  assign wr_en   = init_i.en | cmd_i.push;
  assign wr_addr = init_i.en ? init_i.idx : tail;
  assign wr_data = init_i.en ? init_i.idx : cmd_i.push_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= gta_pkg::cnt_t'(gta_pkg::SLOTS);
      wr_en_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      wr_en_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr;
    wr_data_r <= wr_data;
  end

  gta_ram #(
    .WIDTH (gta_pkg::SLOT_W),
    .DEPTH (gta_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (head_nxt),
    .rdata (ram_q)
  );

  // The RAM returns old data when the head entry was written on the same edge.
  assign free_slot_o = (wr_en_r && (wr_addr_r == head_r)) ? wr_data_r : ram_q;
  assign fill_o      = fill_r;

endmodule

>>> rtl/gta_slot_tab.sv
// Per-slot tag table (valid bit and round) and handle store, with write bypass.
// Depends on gta_pkg and gta_ram.
module gta_slot_tab (
  input  logic             clk,
  input  logic             rst_n,
  input  gta_pkg::init_t   init_i,
  input  gta_pkg::st_cmd_t cmd_i,
  input  gta_pkg::slot_t   rd_slot_i,
  output gta_pkg::tag_t    tag_o,
  output gta_pkg::handle_t handle_o
);

  logic                                tag_we;
  gta_pkg::slot_t                      tag_waddr;
  gta_pkg::tag_t                       tag_wdata;
  logic [$bits(gta_pkg::tag_t)-1:0]    tag_q;
  logic                                hnd_we;
  gta_pkg::handle_t                    hnd_q;

  gta_pkg::slot_t   rd_slot_r;
  logic             tag_we_r, hnd_we_r;
  gta_pkg::slot_t   tag_waddr_r;
  gta_pkg::tag_t    tag_wdata_r;
  gta_pkg::handle_t hnd_wdata_r;

  assign tag_we    = init_i.en | cmd_i.alloc | cmd_i.rel;
  assign tag_waddr = init_i.en ? init_i.idx : cmd_i.slot;
  always_comb begin
    tag_wdata = '0;
    if (!init_i.en && cmd_i.alloc) begin
      tag_wdata.valid = 1'b1;
      tag_wdata.round = cmd_i.round;
    end
  end
  assign hnd_we = cmd_i.alloc & ~init_i.en;

  gta_ram #(
    .WIDTH ($bits(gta_pkg::tag_t)),
    .DEPTH (gta_pkg::SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (rd_slot_i),
    .rdata (tag_q)
  );

  gta_ram #(
    .WIDTH (gta_pkg::HANDLE_W),
    .DEPTH (gta_pkg::SLOTS)
  ) u_hnd_ram (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (cmd_i.slot),
    .wdata (cmd_i.handle),
    .raddr (rd_slot_i),
    .rdata (hnd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_we_r <= 1'b0;
      hnd_we_r <= 1'b0;
    end else begin
      tag_we_r <= tag_we;
      hnd_we_r <= hnd_we;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r   <= rd_slot_i;
    tag_waddr_r <= tag_waddr;
    tag_wdata_r <= tag_wdata;
    hnd_wdata_r <= cmd_i.handle;
  end

  // A write and a read of the same slot on one edge: forward the written value.
  assign tag_o    = (tag_we_r && (tag_waddr_r == rd_slot_r)) ? tag_wdata_r
                                                             : gta_pkg::tag_t'(tag_q);
  assign handle_o = (hnd_we_r && (tag_waddr_r == rd_slot_r)) ? hnd_wdata_r : hnd_q;

endmodule
